@@ rtl/core/dwsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dwsp_pkg
// Types and constants of the dual wheel speed pid core: register codes,
// reset values, datapath widths and the packed stream item layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package dwsp_pkg;

    // configuration register codes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PWM      = 3'd4;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned PWM_W      = 10;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RST       = 16'd20;
    localparam logic [GAIN_W-1:0] GAIN_I_RST       = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST       = 16'd12;
    localparam logic [GAIN_W-1:0] GAIN_DIVISOR_RST = 16'd50;
    localparam logic [PWM_W-1:0]  MAX_PWM_RST      = 10'd255;

    // field widths
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned TARGET_W = 16;
    localparam int unsigned DRIVE_W  = 11;

    // datapath widths: error and speed change fit in 34 bits, a gain product
    // in 51 bits, the summed terms in 52 bits
    localparam int unsigned ERR_W  = 34;
    localparam int unsigned MULA_W = GAIN_W + 1;
    localparam int unsigned PROD_W = MULA_W + ERR_W;
    localparam int unsigned ACC_W  = PROD_W + 1;
    localparam int unsigned DRV_W  = ACC_W + 1;

    // divider: quotient bits retired per cycle and cycles per division
    localparam int unsigned DIV_STEPS = 4;
    localparam int unsigned DIV_ITERS = ACC_W / DIV_STEPS;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_ITERS);

    // input item, last field in the lowest bits
    typedef struct packed {
        logic signed [TARGET_W-1:0] right_target;
        logic signed [TARGET_W-1:0] left_target;
        logic signed [COUNT_W-1:0]  right_count;
        logic signed [COUNT_W-1:0]  left_count;
    } in_item_t;

    // result item, padded with zeros to whole bytes
    typedef struct packed {
        logic [1:0]                pad;
        logic signed [COUNT_W-1:0] right_ticks;
        logic signed [COUNT_W-1:0] left_ticks;
        logic signed [DRIVE_W-1:0] right_drive;
        logic signed [DRIVE_W-1:0] left_drive;
    } out_item_t;

    localparam int unsigned IN_DATA_W  = $bits(in_item_t);
    localparam int unsigned OUT_DATA_W = $bits(out_item_t);

endpackage

`default_nettype wire

@@ rtl/core/dual_wheel_speed_pid_core.sv @@
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid_core
// Incremental PID speed control of two wheels with anti-windup, built on
// one shared multiplier and one radix-16 restoring divider under a sequencer.
// ----------------------------------------------------------------------------
// sequence: for a control tick each wheel in turn runs load, 3 multiplies,
//   divider setup, the divider passes and fixup, then the result is handed
//   over; a clear resets the wheel state and then hands a result over
// requests: a new request is taken only once the sequencer is back in idle;
//   a result still waiting on m_tready holds the handover step
// reset: rst_n clears gains to their defaults and all wheel state to zero
`default_nettype none

module dual_wheel_speed_pid_core
(
    input  wire                              clk,
    input  wire                              rst_n,
    // slave request: tdata = left_count, right_count, left_target, right_target
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [dwsp_pkg::IN_DATA_W-1:0]   s_tdata,
    // tuser = action (0 control tick, 1 clear)
    input  wire                              s_tuser,
    // master result: tdata = left_drive, right_drive, left_ticks, right_ticks, pad
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [dwsp_pkg::OUT_DATA_W-1:0]  m_tdata,
    // configuration write channel
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [dwsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [dwsp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import dwsp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_I,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

    // control and configuration
    state_t                state_reg, state_next;
    logic                  wheel_reg, wheel_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [GAIN_W-1:0]     gain_p_reg, gain_p_next;
    logic [GAIN_W-1:0]     gain_i_reg, gain_i_next;
    logic [GAIN_W-1:0]     gain_d_reg, gain_d_next;
    logic [GAIN_W-1:0]     gain_div_reg, gain_div_next;
    logic [PWM_W-1:0]      max_pwm_reg, max_pwm_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    out_item_t             out_reg, out_next;

    // wheel state
    logic signed [COUNT_W-1:0] last_count_reg [2];
    logic signed [COUNT_W-1:0] last_count_next [2];
    logic signed [COUNT_W-1:0] last_ticks_reg [2];
    logic signed [COUNT_W-1:0] last_ticks_next [2];
    logic signed [COUNT_W-1:0] integ_reg [2];
    logic signed [COUNT_W-1:0] integ_next [2];
    logic signed [DRIVE_W-1:0] drive_reg [2];
    logic signed [DRIVE_W-1:0] drive_next [2];

    // datapath
    in_item_t                  in_reg, in_next;
    logic signed [COUNT_W-1:0] ticks_reg, ticks_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [ERR_W-1:0]   dt_reg, dt_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      neg_reg, neg_next;
    logic [ACC_W-1:0]          dvd_reg, dvd_next;
    logic [GAIN_W-1:0]         rem_reg, rem_next;

    // shared multiplier
    logic signed [MULA_W-1:0]  mul_a;
    logic signed [ERR_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_res;

    // divider step results
    logic [GAIN_W-1:0]         div_eff;
    logic [ACC_W-1:0]          dvd_step;
    logic [GAIN_W-1:0]         rem_step;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_reg;

    // a zero divisor acts as one
    assign div_eff = (gain_div_reg == '0) ? GAIN_W'(1) : gain_div_reg;

    // multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_D:
            begin
                mul_a = $signed({1'b0, gain_d_reg});
                mul_b = dt_reg;
            end
            ST_MUL_I:
            begin
                mul_a = $signed({1'b0, gain_i_reg});
                mul_b = err_reg;
            end
            default:
            begin
                mul_a = $signed({1'b0, gain_p_reg});
                mul_b = err_reg;
            end
        endcase
    end

    assign mul_res = mul_a * mul_b;

    // four restoring division steps on the dividend magnitude
    always_comb
    begin
        logic [GAIN_W:0]  r;
        logic [ACC_W-1:0] d;
        r = {1'b0, rem_reg};
        d = dvd_reg;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            r = {r[GAIN_W-1:0], d[ACC_W-1]};
            d = {d[ACC_W-2:0], 1'b0};
            if (r >= {1'b0, div_eff})
            begin
                r    = r - {1'b0, div_eff};
                d[0] = 1'b1;
            end
        end
        rem_step = r[GAIN_W-1:0];
        dvd_step = d;
    end

    // sequencer and datapath next state
    always_comb
    begin
        logic signed [COUNT_W-1:0] cnt_in;
        logic signed [TARGET_W-1:0] tgt_in;
        logic signed [COUNT_W-1:0] tk;
        logic signed [DRV_W-1:0]   quot;
        logic signed [DRV_W-1:0]   drv;
        logic signed [DRV_W-1:0]   lim;
        logic signed [ACC_W-1:0]   isum;

        state_next      = state_reg;
        wheel_next      = wheel_reg;
        cnt_next        = cnt_reg;
        gain_p_next     = gain_p_reg;
        gain_i_next     = gain_i_reg;
        gain_d_next     = gain_d_reg;
        gain_div_next   = gain_div_reg;
        max_pwm_next    = max_pwm_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_next        = out_reg;
        last_count_next = last_count_reg;
        last_ticks_next = last_ticks_reg;
        integ_next      = integ_reg;
        drive_next      = drive_reg;
        in_next         = in_reg;
        ticks_next      = ticks_reg;
        err_next        = err_reg;
        dt_next         = dt_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;

        cnt_in = wheel_reg ? in_reg.right_count : in_reg.left_count;
        tgt_in = wheel_reg ? in_reg.right_target : in_reg.left_target;
        tk     = cnt_in - last_count_reg[wheel_reg];
        quot   = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
        drv    = quot + DRV_W'(drive_reg[wheel_reg]);
        lim    = $signed({{(DRV_W-PWM_W){1'b0}}, max_pwm_reg});
        isum   = ACC_W'(integ_reg[wheel_reg]) + ACC_W'(prod_reg);

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GAIN_P:       gain_p_next   = cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:       gain_i_next   = cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:       gain_d_next   = cfg_data[GAIN_W-1:0];
                CFG_GAIN_DIVISOR: gain_div_next = cfg_data[GAIN_W-1:0];
                CFG_MAX_PWM:      max_pwm_next  = cfg_data[PWM_W-1:0];
                default:          ;
            endcase
        end

        // result register drains independently
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_next    = s_tdata;
                    wheel_next = 1'b0;
                    state_next = s_tuser ? ST_CLEAR : ST_LOAD;
                end
            end
            ST_CLEAR:
            begin
                last_count_next = '{default: '0};
                last_ticks_next = '{default: '0};
                integ_next      = '{default: '0};
                drive_next      = '{default: '0};
                state_next      = ST_DONE;
            end
            // measured speed, error and speed change
            ST_LOAD:
            begin
                ticks_next = tk;
                err_next   = ERR_W'(tgt_in) - ERR_W'(tk);
                dt_next    = ERR_W'(tk) - ERR_W'(last_ticks_reg[wheel_reg]);
                acc_next   = ACC_W'(integ_reg[wheel_reg]);
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                prod_next  = mul_res;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                prod_next  = mul_res;
                state_next = ST_MUL_I;
            end
            // the integral product stays in prod_reg for the fixup
            ST_MUL_I:
            begin
                acc_next   = acc_reg - ACC_W'(prod_reg);
                prod_next  = mul_res;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                neg_next   = acc_reg[ACC_W-1];
                dvd_next   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_ITERS - 1))
                begin
                    state_next = ST_FIX;
                end
            end
            // new drive with clamp, integral only grows when unclamped
            ST_FIX:
            begin
                priority if (drv >= lim)
                begin
                    drive_next[wheel_reg] = DRIVE_W'(lim);
                end
                else if (drv <= -lim)
                begin
                    drive_next[wheel_reg] = DRIVE_W'(-lim);
                end
                else
                begin
                    drive_next[wheel_reg] = DRIVE_W'(drv);
                    priority if (isum > ACC_W'(32'sh7fff_ffff))
                    begin
                        integ_next[wheel_reg] = 32'sh7fff_ffff;
                    end
                    else if (isum < -ACC_W'(33'sh0_8000_0000))
                    begin
                        integ_next[wheel_reg] = 32'sh8000_0000;
                    end
                    else
                    begin
                        integ_next[wheel_reg] = COUNT_W'(isum);
                    end
                end
                last_count_next[wheel_reg] = cnt_in;
                last_ticks_next[wheel_reg] = ticks_reg;
                if (wheel_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    wheel_next = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            // hand the result over once the output register is free
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next.pad         = '0;
                    out_next.left_drive  = drive_reg[0];
                    out_next.right_drive = drive_reg[1];
                    out_next.left_ticks  = last_ticks_reg[0];
                    out_next.right_ticks = last_ticks_reg[1];
                    m_tvalid_next        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wheel_reg      <= 1'b0;
            cnt_reg        <= '0;
            gain_p_reg     <= GAIN_P_RST;
            gain_i_reg     <= GAIN_I_RST;
            gain_d_reg     <= GAIN_D_RST;
            gain_div_reg   <= GAIN_DIVISOR_RST;
            max_pwm_reg    <= MAX_PWM_RST;
            m_tvalid_reg   <= 1'b0;
            last_count_reg <= '{default: '0};
            last_ticks_reg <= '{default: '0};
            integ_reg      <= '{default: '0};
            drive_reg      <= '{default: '0};
        end
        else
        begin
            state_reg      <= state_next;
            wheel_reg      <= wheel_next;
            cnt_reg        <= cnt_next;
            gain_p_reg     <= gain_p_next;
            gain_i_reg     <= gain_i_next;
            gain_d_reg     <= gain_d_next;
            gain_div_reg   <= gain_div_next;
            max_pwm_reg    <= max_pwm_next;
            m_tvalid_reg   <= m_tvalid_next;
            last_count_reg <= last_count_next;
            last_ticks_reg <= last_ticks_next;
            integ_reg      <= integ_next;
            drive_reg      <= drive_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        in_reg    <= in_next;
        ticks_reg <= ticks_next;
        err_reg   <= err_next;
        dt_reg    <= dt_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
    end

    // an accepted request always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("accepted request left the sequencer idle");

    // divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < div_eff)
        else $error("divider remainder out of range");

    // drives are always clamped inside the 10 bit limit
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_reg.left_drive != 11'sh400 && out_reg.right_drive != 11'sh400)
        else $error("drive outside clamp range");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("pending result dropped");

endmodule

`default_nettype wire

@@ bench/dwsp_bench_pkg.sv @@
// ----------------------------------------------------------------------------
// dwsp_bench_pkg
// Codes shared by the bench files of the dual wheel speed pid core: the
// request action carried on the slave tuser line.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package dwsp_bench_pkg;

    // request action on s_tuser
    typedef enum logic
    {
        ACT_TICK  = 1'b0,
        ACT_CLEAR = 1'b1
    } pid_action_t;

endpackage

@@ bench/dwsp_pid_checker.sv @@
// ----------------------------------------------------------------------------
// dwsp_pid_checker
// Passive checker of the dual wheel speed pid core. Tracks register writes,
// runs its own copy of the two wheel controllers on every accepted request
// and compares each accepted result, field by field, with the oldest
// prediction. Hands the mismatch count and the backlog to the bench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dwsp_pid_checker
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    input  wire                              s_tready,
    input  wire  [dwsp_pkg::IN_DATA_W-1:0]   s_tdata,
    input  wire                              s_tuser,
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    input  wire  [dwsp_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire                              cfg_valid,
    input  wire                              cfg_ready,
    input  wire  [dwsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [dwsp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               outstanding,
    output int                               checked_count,
    output int                               clamp_count,
    output int                               sat_count
);

    import dwsp_pkg::*;
    import dwsp_bench_pkg::*;

    localparam longint INTEG_MAX   = 64'sd2147483647;
    localparam longint INTEG_MIN   = -64'sd2147483648;

    // register shadow
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [GAIN_W-1:0] gain_divisor;
    logic [PWM_W-1:0]  max_pwm;

    // per wheel controller state, 0 left, 1 right
    logic signed [COUNT_W-1:0] prev_count [2];
    logic signed [COUNT_W-1:0] prev_ticks [2];
    logic signed [COUNT_W-1:0] integ      [2];
    logic signed [DRIVE_W-1:0] drive_now  [2];

    // predicted results in request order
    out_item_t drive_forecast [$];

    out_item_t                 got;
    out_item_t                 want;
    in_item_t                  req;
    logic signed [DRIVE_W-1:0] drv_l;
    logic signed [DRIVE_W-1:0] drv_r;
    logic signed [COUNT_W-1:0] tick_l;
    logic signed [COUNT_W-1:0] tick_r;

    // one line per mismatch
    task automatic flag_mismatch(input string what, input longint seen, input longint wanted);
        begin
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $time, checked_count, what, seen, wanted);
            fail_count = fail_count + 1;
        end
    endtask

    // one control tick of one wheel: speed, pid step, clamp, anti-windup
    task automatic step_wheel(input int w,
                              input logic signed [COUNT_W-1:0] count,
                              input logic signed [TARGET_W-1:0] target,
                              output logic signed [DRIVE_W-1:0] drive,
                              output logic signed [COUNT_W-1:0] ticks);
        longint err;
        longint divisor;
        longint limit;
        longint next_drive;
        longint grown;
        begin
            ticks = count - prev_count[w];
            err = longint'(target) - longint'(ticks);
            divisor = (gain_divisor == '0) ? 64'sd1 : longint'(gain_divisor);
            limit = longint'(max_pwm);
            next_drive = (longint'(gain_p) * err
                          - longint'(gain_d) * (longint'(ticks) - longint'(prev_ticks[w]))
                          + longint'(integ[w])) / divisor
                         + longint'(drive_now[w]);
            if (next_drive >= limit)
            begin
                next_drive = limit;
                clamp_count = clamp_count + 1;
            end
            else if (next_drive <= -limit)
            begin
                next_drive = -limit;
                clamp_count = clamp_count + 1;
            end
            else
            begin
                // integral only grows while the drive is inside the limit
                grown = longint'(integ[w]) + longint'(gain_i) * err;
                if (grown > INTEG_MAX)
                begin
                    grown = INTEG_MAX;
                    sat_count = sat_count + 1;
                end
                else if (grown < INTEG_MIN)
                begin
                    grown = INTEG_MIN;
                    sat_count = sat_count + 1;
                end
                integ[w] = grown[COUNT_W-1:0];
            end
            drive = next_drive[DRIVE_W-1:0];
            drive_now[w] = drive;
            prev_count[w] = count;
            prev_ticks[w] = ticks;
        end
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p       = GAIN_P_RST;
            gain_i       = GAIN_I_RST;
            gain_d       = GAIN_D_RST;
            gain_divisor = GAIN_DIVISOR_RST;
            max_pwm      = MAX_PWM_RST;
            for (int w = 0; w < 2; w++)
            begin
                prev_count[w] = '0;
                prev_ticks[w] = '0;
                integ[w]      = '0;
                drive_now[w]  = '0;
            end
            drive_forecast.delete();
            outstanding = 0;
        end
        else
        begin
            // results: compare with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (drive_forecast.size() == 0)
                    flag_mismatch("result with nothing pending, left_drive",
                                  got.left_drive, 0);
                else
                begin
                    want = drive_forecast.pop_front();
                    if (got.left_drive !== want.left_drive)
                        flag_mismatch("left_drive", got.left_drive, want.left_drive);
                    if (got.right_drive !== want.right_drive)
                        flag_mismatch("right_drive", got.right_drive, want.right_drive);
                    if (got.left_ticks !== want.left_ticks)
                        flag_mismatch("left_ticks", got.left_ticks, want.left_ticks);
                    if (got.right_ticks !== want.right_ticks)
                        flag_mismatch("right_ticks", got.right_ticks, want.right_ticks);
                    if (got.pad !== want.pad)
                        flag_mismatch("pad", got.pad, want.pad);
                end
                checked_count = checked_count + 1;
            end

            // register writes, unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAIN_P:       gain_p       = cfg_data;
                    CFG_GAIN_I:       gain_i       = cfg_data;
                    CFG_GAIN_D:       gain_d       = cfg_data;
                    CFG_GAIN_DIVISOR: gain_divisor = cfg_data;
                    CFG_MAX_PWM:      max_pwm      = cfg_data[PWM_W-1:0];
                    default:          ;
                endcase
            end

            // requests: predict the result
            if (s_tvalid && s_tready)
            begin
                req = s_tdata;
                want = '0;
                if (s_tuser == ACT_CLEAR)
                begin
                    for (int w = 0; w < 2; w++)
                    begin
                        prev_count[w] = '0;
                        prev_ticks[w] = '0;
                        integ[w]      = '0;
                        drive_now[w]  = '0;
                    end
                end
                else
                begin
                    step_wheel(0, req.left_count, req.left_target, drv_l, tick_l);
                    step_wheel(1, req.right_count, req.right_target, drv_r, tick_r);
                    want.left_drive  = drv_l;
                    want.right_drive = drv_r;
                    want.left_ticks  = tick_l;
                    want.right_ticks = tick_r;
                end
                drive_forecast.push_back(want);
            end

            outstanding = drive_forecast.size();
        end
    end

endmodule

@@ bench/dual_wheel_speed_pid_core_tb.sv @@
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid_core_tb
// Drives control ticks and clears into the dual wheel speed pid core under
// a series of gain settings, with bursty requests and a stalling result
// side. A checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dual_wheel_speed_pid_core_tb;

    import dwsp_pkg::*;
    import dwsp_bench_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int QUIET_LIMIT     = 3000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int DRAIN_CYCLES    = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int checked_count;
    int clamp_count;
    int sat_count;

    int idle_cycles;
    int burst_left;
    int stall_left;
    int stall_phase;
    bit calm_sender;
    bit stalling_receiver;
    int ticks_sent;
    int clears_sent;
    int reg_writes;

    // running encoder positions for well-formed tick sequences
    logic signed [COUNT_W-1:0] enc_left;
    logic signed [COUNT_W-1:0] enc_right;

    dual_wheel_speed_pid_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dwsp_pid_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count),
        .clamp_count   (clamp_count),
        .sat_count     (sat_count)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // result side: stall runs in some stretches, always ready in others
    always @(negedge clk)
    begin
        stall_phase = stall_phase + 1;
        if (stall_phase % 300 == 0)
            stalling_receiver = ($urandom_range(0, 2) != 0);
        if (stall_left > 0)
        begin
            m_tready = 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            m_tready = 1'b1;
            if (stalling_receiver && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 14);
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= QUIET_LIMIT)
        begin
            $display("nothing moved for %0d cycles, %0d results pending",
                     QUIET_LIMIT, outstanding);
            $display("Some tests failed");
            $finish;
        end
    end

    // one request, sent in bursts with random gaps between them unless the sender is calm
    task automatic send_request(input pid_action_t act,
                                input logic signed [COUNT_W-1:0] left_count,
                                input logic signed [COUNT_W-1:0] right_count,
                                input logic signed [TARGET_W-1:0] left_target,
                                input logic signed [TARGET_W-1:0] right_target);
        in_item_t req;
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = calm_sender ? 0 : $urandom_range(0, 20);
                if (gap > 0)
                begin
                    s_tvalid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left = burst_left - 1;
            req.left_count   = left_count;
            req.right_count  = right_count;
            req.left_target  = left_target;
            req.right_target = right_target;
            s_tdata  = req;
            s_tuser  = act;
            s_tvalid = 1'b1;
            do
                @(posedge clk);
            while (!s_tready);
            @(negedge clk);
            if (act == ACT_CLEAR)
                clears_sent = clears_sent + 1;
            else
                ticks_sent = ticks_sent + 1;
        end
    endtask

    // one register write request
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        begin
            cfg_index = index;
            cfg_data  = value;
            cfg_valid = 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
            cfg_valid = 1'b0;
            reg_writes = reg_writes + 1;
        end
    endtask

    // wait until every predicted result has come back
    task automatic settle();
        begin
            s_tvalid = 1'b0;
            while (outstanding != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    // full gain set, written once the core is idle
    task automatic write_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                               input logic [GAIN_W-1:0] d, input logic [GAIN_W-1:0] div,
                               input logic [CFG_DATA_W-1:0] limit);
        begin
            settle();
            write_reg(CFG_GAIN_P, p);
            write_reg(CFG_GAIN_I, i);
            write_reg(CFG_GAIN_D, d);
            write_reg(CFG_GAIN_DIVISOR, div);
            write_reg(CFG_MAX_PWM, limit);
        end
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'(1);
            3:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 80));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_divisor();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return GAIN_W'(1);
            2:       return '1;
            3:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(10, 400));
        endcase
    endfunction

    // drive limit, upper data bits random since the core keeps only the low ten
    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        logic [CFG_DATA_W-1:0] value;
        value = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 9))
            0:       value[PWM_W-1:0] = '0;
            1:       value[PWM_W-1:0] = PWM_W'(1);
            2:       value[PWM_W-1:0] = '1;
            default: value[PWM_W-1:0] = PWM_W'($urandom_range(40, 1023));
        endcase
        return value;
    endfunction

    function automatic logic signed [COUNT_W-1:0] extreme_count();
        case ($urandom_range(0, 3))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // mostly smooth encoder motion, some clears, jumps and extremes
    task automatic send_random_request();
        int pick;
        logic signed [TARGET_W-1:0] left_target;
        logic signed [TARGET_W-1:0] right_target;
        begin
            pick = $urandom_range(0, 99);
            left_target  = TARGET_W'(int'($urandom_range(0, 400)) - 200);
            right_target = TARGET_W'(int'($urandom_range(0, 400)) - 200);
            if (pick < 3)
            begin
                enc_left  = '0;
                enc_right = '0;
                send_request(ACT_CLEAR, $urandom, $urandom,
                             TARGET_W'($urandom), TARGET_W'($urandom));
            end
            else if (pick < 88)
            begin
                enc_left  = enc_left + (int'($urandom_range(0, 600)) - 300);
                enc_right = enc_right + (int'($urandom_range(0, 600)) - 300);
                send_request(ACT_TICK, enc_left, enc_right, left_target, right_target);
            end
            else if (pick < 95)
            begin
                enc_left  = $urandom;
                enc_right = $urandom;
                send_request(ACT_TICK, enc_left, enc_right,
                             TARGET_W'($urandom), TARGET_W'($urandom));
            end
            else
            begin
                enc_left  = extreme_count();
                enc_right = extreme_count();
                send_request(ACT_TICK, enc_left, enc_right,
                             ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000,
                             ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000);
            end
        end
    endtask

    // stimulus
    initial
    begin
        int phase;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_TICK;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GAIN_P;
        cfg_data  = '0;
        enc_left  = '0;
        enc_right = '0;
        calm_sender = 1'b0;
        stalling_receiver = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset gains: zero item, count extremes, wraparound both ways, clear
        send_request(ACT_TICK, '0, '0, '0, '0);
        send_request(ACT_TICK, 32'sd100, -32'sd100, 16'sd50, -16'sd50);
        send_request(ACT_TICK, 32'sh7fffffff, 32'sh80000000, 16'sh7fff, 16'sh8000);
        send_request(ACT_TICK, 32'sh80000000, 32'sh7fffffff, 16'sh8000, 16'sh7fff);
        send_request(ACT_TICK, '1, '0, '0, '0);
        send_request(ACT_CLEAR, 32'sh12345678, 32'sh9abcdef0, 16'sh1357, 16'sh9bdf);
        send_request(ACT_TICK, 32'sh55555555, 32'shaaaaaaaa, 16'sh5555, 16'shaaaa);

        // integral saturation at both ends, then clamping on the saturated sum
        write_gains('0, '1, '0, '1, 16'd1023);
        send_request(ACT_CLEAR, '0, '0, '0, '0);
        send_request(ACT_TICK, 32'sh40000000, 32'shc0000000, '0, '0);
        send_request(ACT_TICK, 32'sh40000000, 32'shc0000000, 16'sh7fff, 16'sh8000);
        send_request(ACT_TICK, 32'sh40000005, 32'shc0000005, '0, '0);

        // zero divisor and zero limit, then a limit of one
        write_gains('1, '1, '1, '0, 16'hfc00);
        send_request(ACT_TICK, 32'sd1000, -32'sd1000, 16'sd10, -16'sd10);
        send_request(ACT_TICK, 32'sd900, -32'sd900, 16'sh7fff, 16'sh8000);
        settle();
        write_reg(CFG_MAX_PWM, 16'hfc01);
        send_request(ACT_TICK, 32'sd905, -32'sd905, 16'sd3, -16'sd3);
        send_request(ACT_TICK, 32'sd905, -32'sd905, -16'sd3, 16'sd3);

        // writes to unused indexes must leave the gains alone
        write_gains(16'd40, 16'd3, 16'd10, 16'd25, 16'd500);
        write_reg(CFG_MAX_PWM + 3'd1, 16'h0000);
        write_reg(CFG_MAX_PWM + 3'd2, 16'h0003);
        write_reg(CFG_MAX_PWM + 3'd3, 16'h7fff);
        send_request(ACT_TICK, 32'sd950, -32'sd870, 16'sd60, -16'sd90);
        send_request(ACT_TICK, 32'sd1010, -32'sd950, 16'sd60, -16'sd90);

        // random phases, each under its own gain setting
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_gains(pick_gain(), pick_gain(), pick_gain(), pick_divisor(), pick_limit());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_MAX_PWM + CFG_IDX_W'($urandom_range(1, 3)),
                          CFG_DATA_W'($urandom));
            calm_sender = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) != 0)
            begin
                enc_left  = '0;
                enc_right = '0;
                send_request(ACT_CLEAR, $urandom, $urandom,
                             TARGET_W'($urandom), TARGET_W'($urandom));
            end
            repeat (ITEMS_PER_PHASE) send_random_request();
        end

        // drain and verdict
        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("sent %0d control ticks and %0d clears across %0d register writes",
                 ticks_sent, clears_sent, reg_writes);
        $display("%0d results checked, drive limit reached on %0d wheel ticks, %0d %s",
                 checked_count, clamp_count, sat_count, "integral saturations");
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dwsp_pkg.sv
rtl/core/dual_wheel_speed_pid_core.sv
bench/dwsp_bench_pkg.sv
bench/dwsp_pid_checker.sv
bench/dual_wheel_speed_pid_core_tb.sv
